// ===== hdl/fpt_pkg.sv =====
// Shared constants and types for the flow pulse totalizer.
// No dependencies; imported by fpt_div and flow_pulse_totalizer_top.
package fpt_pkg;

	localparam int NUM_SENSORS_DEF = 8;

	localparam int IDX_W   = 3;
	localparam int RAW_W   = 32;
	localparam int SCALE_W = 32;
	localparam int TOTAL_W = 64;
	localparam int STAT_W  = 2;

	// remainder plus delta needs one more bit than a raw count
	localparam int DIVIDEND_W = RAW_W + 1;
	localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

	localparam logic [STAT_W-1:0] STAT_COUNTED  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BASELINE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROP     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd3;

	typedef struct packed {
		logic [RAW_W-1:0]   base_count;
		logic [TOTAL_W-1:0] total;
		logic [SCALE_W-1:0] rem;
	} entry_t;

endpackage

// ===== hdl/fpt_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fpt_pkg for widths.
module fpt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fpt_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [fpt_pkg::SCALE_W-1:0]     divisor,
	output logic                            done,
	output logic [fpt_pkg::DIVIDEND_W-1:0]  quot,
	output logic [fpt_pkg::SCALE_W-1:0]     rem
);
	import fpt_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] q_q;
	logic [SCALE_W-1:0]    rem_q;
	logic [SCALE_W-1:0]    dvs_q;

	logic [SCALE_W:0] trial;
	logic [SCALE_W:0] diff;
	logic             qbit;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, q_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[DIVIDEND_W-2:0], qbit};
			// remainder stays below the divisor, so the top bit is always clear
			rem_q <= qbit ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = rem_q;

endmodule

// ===== hdl/flow_pulse_totalizer_top.sv =====
// Flow pulse totalizer, top level: per-sensor state memory, control sequencer,
// output register. Depends on fpt_pkg and fpt_div.
//
// Takes one reading (sensor index in s_tuser, raw cumulative count in s_tdata)
// at a time and returns one result (status in m_tuser, 64-bit litre total in
// m_tdata). For a counted or drop reading the state entry is read at the input
// transfer edge; the sequencer then decides, the bit-serial divider works through
// the 33-bit sum of held remainder and delta (one quotient bit per cycle), the
// entry is written back, and the output register is loaded. Baseline and ignored
// readings skip the divider. The next input is taken in the cycle after the
// result is loaded, so a reading holds the input side until its result is
// loaded, even while that result still waits on m_tready; a result still waiting
// at load time stalls the load.
// Per-sensor state sits in a small memory; seeded flags live in flip-flops
// cleared by reset, and an entry that is not seeded reads as zero total and its
// remainder is not used, so no clearing pass is needed after reset. The litre
// scale (raw counts per litre) resets to 1 and is written through cfg_wr_en/
// cfg_wr_data by the user only while the block is idle; the block leaves this unchecked.
module flow_pulse_totalizer_top #(
	parameter int NUM_SENSORS = fpt_pkg::NUM_SENSORS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: litre scale, raw counts per litre
	input  logic                         cfg_wr_en,
	input  logic [fpt_pkg::SCALE_W-1:0]  cfg_wr_data,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // [31:0] raw_count
	input  logic [fpt_pkg::IDX_W-1:0]    s_tuser,   // [2:0] sensor_index
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [63:0]                  m_tdata,   // [63:0] total_litres
	output logic [fpt_pkg::STAT_W-1:0]   m_tuser    // [1:0] status
);
	import fpt_pkg::*;

	localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [SCALE_W-1:0]     upl_q;
	logic [IDX_W-1:0]       idx_q;
	logic [RAW_W-1:0]       raw_q;
	entry_t                 rd_q;
	logic [NUM_SENSORS-1:0] seeded_q;
	logic [STAT_W-1:0]      stat_q;
	logic [TOTAL_W-1:0]     res_total_q;

	logic                   m_tvalid_q;
	logic [STAT_W-1:0]      m_stat_q;
	logic [TOTAL_W-1:0]     m_total_q;

	entry_t                 mem [NUM_SENSORS];

	logic                   in_xfer;
	logic [AW-1:0]          addr_in;
	logic [AW-1:0]          addr;
	logic                   in_range;
	logic                   seeded;
	logic                   rising;
	logic [RAW_W-1:0]       delta;
	logic [DIVIDEND_W-1:0]  units;
	logic [TOTAL_W-1:0]     new_total;

	logic                   mem_we;
	entry_t                 mem_wdata;
	logic                   div_start;
	logic                   div_done;
	logic [DIVIDEND_W-1:0]  div_quot;
	logic [SCALE_W-1:0]     div_rem;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign addr_in  = AW'(s_tuser);
	assign addr     = AW'(idx_q);
	assign in_range = (int'(idx_q) < NUM_SENSORS);
	assign seeded   = in_range && seeded_q[addr];

	// a reading below the baseline adds nothing
	assign rising    = (raw_q >= rd_q.base_count);
	assign delta     = rising ? (raw_q - rd_q.base_count) : '0;
	assign units     = {1'b0, rd_q.rem} + {1'b0, delta};
	assign new_total = rd_q.total + TOTAL_W'(div_quot);

	// unseeded entries read as zero total; their remainder is not used
	logic [TOTAL_W-1:0] cur_total;
	assign cur_total = seeded ? rd_q.total : '0;

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '{base_count: raw_q, total: new_total, rem: div_rem};
		div_start = 1'b0;
		case (state_q)
			S_EVAL: begin
				if (in_range && upl_q != '0) begin
					if (!seeded) begin
						mem_we    = 1'b1;
						mem_wdata = '{base_count: raw_q, total: '0, rem: '0};
					end else begin
						div_start = 1'b1;
					end
				end
			end
			S_DIV: begin
				mem_we = div_done;
			end
			default: begin
			end
		endcase
	end

	fpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (units),
		.divisor  (upl_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// state memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= mem_wdata;
		if (in_xfer)
			rd_q <= mem[addr_in];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_q <= s_tuser;
			raw_q <= s_tdata;
		end
		case (state_q)
			S_EVAL: begin
				if (!in_range) begin
					stat_q      <= STAT_IGNORED;
					res_total_q <= '0;
				end else if (upl_q == '0) begin
					stat_q      <= STAT_IGNORED;
					res_total_q <= cur_total;
				end else if (!seeded) begin
					stat_q      <= STAT_BASELINE;
					res_total_q <= '0;
				end else begin
					stat_q      <= rising ? STAT_COUNTED : STAT_DROP;
				end
			end
			S_DIV: begin
				if (div_done)
					res_total_q <= new_total;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			upl_q      <= SCALE_W'(1);
			seeded_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				upl_q <= cfg_wr_data;
			// load the output register once the previous result is gone
			if (state_q == S_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (in_range && upl_q != '0 && seeded)
						state_q <= S_DIV;
					else
						state_q <= S_DONE;
					if (in_range && upl_q != '0 && !seeded)
						seeded_q[addr] <= 1'b1;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_stat_q  <= stat_q;
			m_total_q <= res_total_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = m_total_q;

	// divider finishes only while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide phase");

	// every input transfer is followed by the decide cycle
	a_xfer_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_EVAL)
		else $error("input transfer not followed by evaluation");

	// a new result shows up only from the output-load step
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("result valid raised outside output load");

	// state is written only for sensors that exist, and never with a zero scale
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (in_range && upl_q != '0))
		else $error("state write for ignored reading");

endmodule
